// ===== design/gwa_pkg.sv =====
package gwa_pkg;

    localparam int NUM_GROUPS = 64;
    localparam int COMPONENTS = 3;
    localparam int GROUP_W = 6;
    localparam int SUM_W = 64;
    localparam int VAL_W = 32;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam int IN_TDATA_W = 136;
    localparam int OUT_TDATA_W = 104;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ACCUM,
        ST_EMIT_READ,
        ST_EMIT_LOAD,
        ST_DIVIDE,
        ST_OUTPUT,
        ST_NEXT
    } gwa_state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic                 capture;    // latch the input item
        logic                 rd_item;    // read memories at the item's group
        logic                 wr_accum;   // write back accumulated entry
        logic                 rd_emit;    // read memories at the emit counter
        logic                 clr_entry;  // write zero at the emit/clear counter
        logic                 div_start;  // load the dividers
        logic                 out_load;   // load the output register
        logic [GROUP_W-1:0]   addr;       // emit / clear address
        logic                 last_grp;   // result is the final of the run
        logic                 reset_high; // clear highest group
    } gwa_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic                 div_done;
        logic [GROUP_W-1:0]   highest;
        logic                 item_last;
    } gwa_stat_t;

endpackage

// ===== design/gwa_ctrl.sv =====
module gwa_ctrl import gwa_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      m_tvalid,
    input  logic      m_tready,
    input  gwa_stat_t stat,
    output gwa_cmd_t  cmd
);

    gwa_state_t         state_reg, state_next;
    logic [GROUP_W:0]   cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        s_tready       = 1'b0;
        cmd            = '0;
        cmd.addr       = cnt_reg[GROUP_W-1:0];
        cmd.last_grp   = (cnt_reg[GROUP_W-1:0] == stat.highest);
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_entry = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (GROUP_W+1)'(NUM_GROUPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = !m_tvalid;
                if (s_tvalid && !m_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_item = 1'b1;
                state_next  = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.wr_accum = 1'b1;
                cnt_next     = '0;
                state_next   = stat.item_last ? ST_EMIT_READ : ST_IDLE;
            end
            ST_EMIT_READ: begin
                cmd.rd_emit = 1'b1;
                state_next  = ST_EMIT_LOAD;
            end
            ST_EMIT_LOAD: begin
                cmd.div_start = 1'b1;
                cmd.clr_entry = 1'b1;
                state_next    = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (stat.div_done) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (!m_tvalid || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_NEXT;
                end
            end
            ST_NEXT: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[GROUP_W-1:0] == stat.highest) begin
                    cmd.reset_high = 1'b1;
                    cnt_next       = '0;
                    state_next     = ST_IDLE;
                end else begin
                    state_next = ST_EMIT_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== design/gwa_div.sv =====
module gwa_div import gwa_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [SUM_W-1:0]        dividend,
    input  logic [SUM_W-1:0]        divisor,
    output logic                    done,
    output logic [SUM_W-1:0]        quotient
);

    logic [SUM_W-1:0]         quo_reg, quo_next;
    logic [SUM_W:0]           rem_reg, rem_next;
    logic [SUM_W-1:0]         den_reg;
    logic [$clog2(SUM_W):0]   cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic [SUM_W:0]           trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[SUM_W-1:0], quo_reg[SUM_W-1]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = trial - {1'b0, den_reg};
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ($clog2(SUM_W)+1)'(SUM_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= divisor;
        end
    end

    assign done     = !busy_reg && !start;
    assign quotient = quo_reg;

endmodule

// ===== design/gwa_dp.sv =====
module gwa_dp import gwa_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  gwa_cmd_t                 cmd,
    output gwa_stat_t                stat,
    input  logic                     cfg_method,
    input  logic [IN_TDATA_W-1:0]    in_data,
    input  logic                     in_last,
    input  logic                     m_tready,
    output logic                     m_tvalid,
    output logic [OUT_TDATA_W-1:0]   m_tdata,
    output logic [1:0]               m_tuser
);

    logic [SUM_W-1:0] sum_mem [COMPONENTS][NUM_GROUPS];
    logic [SUM_W-1:0] wgt_mem [NUM_GROUPS];

    logic [GROUP_W-1:0] grp_reg;
    logic [VAL_W-1:0]   val_reg [COMPONENTS];
    logic [VAL_W-1:0]   area_reg;
    logic               last_reg, method_reg;
    logic [GROUP_W-1:0] high_reg;

    logic [SUM_W-1:0]   rsum_reg [COMPONENTS];
    logic [SUM_W-1:0]   rwgt_reg;
    logic [SUM_W-1:0]   add_reg [COMPONENTS];
    logic signed [SUM_W:0] prod [COMPONENTS];

    logic [GROUP_W-1:0] wr_addr;
    logic [SUM_W-1:0]   new_sum [COMPONENTS];
    logic [SUM_W-1:0]   new_wgt;
    logic [SUM_W:0]     wgt_ext;

    logic               empty_reg;
    logic [COMPONENTS-1:0] neg_reg;
    logic [COMPONENTS-1:0] dv_done;
    logic [SUM_W-1:0]   quo [COMPONENTS];
    logic [SUM_W-1:0]   mag [COMPONENTS];
    logic [VAL_W-1:0]   mean [3];
    logic               mvalid_reg;
    logic [OUT_TDATA_W-1:0] mdata_reg;
    logic [1:0]         muser_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            grp_reg    <= in_data[GROUP_W-1:0];
            area_reg   <= in_data[GROUP_W+3*VAL_W +: VAL_W];
            last_reg   <= in_last;
            method_reg <= cfg_method;
        end
        for (int j = 0; j < COMPONENTS; j++) begin
            if (cmd.capture) begin
                val_reg[j] <= in_data[GROUP_W + j*VAL_W +: VAL_W];
            end
        end
    end

    // A signed 32-bit value times an unsigned 32-bit area always fits in 64 bits.
    always_comb begin
        for (int j = 0; j < COMPONENTS; j++) begin
            prod[j] = $signed(val_reg[j]) * $signed({1'b0, area_reg});
        end
    end

    // Product terms (in count mode, the sign-extended values) are registered before the accumulate add.
    always_ff @(posedge aclk) begin
        for (int j = 0; j < COMPONENTS; j++) begin
            if (cmd.rd_item) begin
                if (method_reg) begin
                    add_reg[j] <= prod[j][SUM_W-1:0];
                end else begin
                    add_reg[j] <= {{32{val_reg[j][VAL_W-1]}}, val_reg[j]};
                end
            end
        end
    end

    // Memory reads and writes.
    assign wr_addr = cmd.wr_accum ? grp_reg : cmd.addr;

    always_comb begin
        wgt_ext = {1'b0, rwgt_reg} + (method_reg ? {33'd0, area_reg} : 65'd1);
        new_wgt = wgt_ext[SUM_W] ? {SUM_W{1'b1}} : wgt_ext[SUM_W-1:0];
        for (int j = 0; j < COMPONENTS; j++) begin
            new_sum[j] = rsum_reg[j] + add_reg[j];
            if (rsum_reg[j][SUM_W-1] == add_reg[j][SUM_W-1]
                && new_sum[j][SUM_W-1] != rsum_reg[j][SUM_W-1]) begin
                new_sum[j] = rsum_reg[j][SUM_W-1] ? SUM_MIN : SUM_MAX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < COMPONENTS; j++) begin
            if (cmd.rd_item) begin
                rsum_reg[j] <= sum_mem[j][grp_reg];
            end else if (cmd.rd_emit) begin
                rsum_reg[j] <= sum_mem[j][cmd.addr];
            end
            if (cmd.wr_accum) begin
                sum_mem[j][wr_addr] <= new_sum[j];
            end else if (cmd.clr_entry) begin
                sum_mem[j][wr_addr] <= '0;
            end
        end
        if (cmd.rd_item) begin
            rwgt_reg <= wgt_mem[grp_reg];
        end else if (cmd.rd_emit) begin
            rwgt_reg <= wgt_mem[cmd.addr];
        end
        if (cmd.wr_accum) begin
            wgt_mem[wr_addr] <= new_wgt;
        end else if (cmd.clr_entry) begin
            wgt_mem[wr_addr] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.reset_high) begin
            high_reg <= '0;
        end else if (cmd.wr_accum && grp_reg > high_reg) begin
            high_reg <= grp_reg;
        end
    end

    // Dividers run on magnitudes; signs are restored afterward.
    for (genvar j = 0; j < COMPONENTS; j++) begin : g_div
        assign mag[j] = rsum_reg[j][SUM_W-1] ? (~rsum_reg[j] + 1'b1) : rsum_reg[j];
        gwa_div u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (cmd.div_start),
            .dividend (mag[j]),
            .divisor  (rwgt_reg),
            .done     (dv_done[j]),
            .quotient (quo[j])
        );
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            empty_reg <= (rwgt_reg == '0);
            for (int j = 0; j < COMPONENTS; j++) begin
                neg_reg[j] <= rsum_reg[j][SUM_W-1];
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            mean[j] = '0;
        end
        for (int j = 0; j < COMPONENTS; j++) begin
            if (empty_reg) begin
                mean[j] = '0;
            end else if (neg_reg[j]) begin
                mean[j] = (quo[j] >= 64'h8000_0000) ? 32'h8000_0000
                        : (~quo[j][VAL_W-1:0] + 1'b1);
            end else begin
                mean[j] = (quo[j] > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo[j][VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            mdata_reg <= {2'b00, mean[2], mean[1], mean[0], cmd.addr};
            muser_reg <= {cmd.last_grp, empty_reg};
        end
    end

    assign m_tvalid       = mvalid_reg;
    assign m_tdata        = mdata_reg;
    assign m_tuser        = muser_reg;
    assign stat.div_done  = &dv_done;
    assign stat.highest   = high_reg;
    assign stat.item_last = last_reg;

endmodule

// ===== design/grouped_weighted_average.sv =====
// Grouped weighted average.
// Input transactions on s_* carry one triangle: group id, three signed
// component values and an unsigned Q16.16 area; s_tlast marks the final
// triangle of a set. Each triangle is accumulated into per-group sums and
// weights kept in on-chip memories with a read-modify-write, so one input
// transaction goes through capture, read/multiply and write back in turn.
// The triangle marked last triggers an emission run: groups 0 up to the
// highest group seen are each read, divided by three 64-step restoring
// dividers running in parallel, and sent as one m_* transaction. Each group
// is read, loaded into the bit-serial dividers, divided and output before
// the next group is read.
// Each emitted entry is cleared as it is read. m_tlast marks the final
// group of the run.
// The cfg channel writes average_method (0 count, 1 area weighted); it is
// sampled with each triangle. After reset the block sweeps all 64 memory
// entries with s_tready low. If the receiver stalls, the result stays
// in the output register and the emission run waits; no result is lost.
module grouped_weighted_average import gwa_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // group_id[5:0], value_a[37:6], value_b[69:38], value_c[101:70],
    // area[133:102], zero pad
    input  logic [IN_TDATA_W-1:0]   s_tdata,
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // group_index[5:0], mean_a[37:6], mean_b[69:38], mean_c[101:70], zero pad
    output logic [OUT_TDATA_W-1:0]  m_tdata,
    // empty_group[0]
    output logic                    m_tuser,
    output logic                    m_tlast,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data
);

    gwa_cmd_t  cmd;
    gwa_stat_t stat;
    logic      method_reg;
    logic [1:0] user;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            method_reg <= cfg_data;
        end
    end

    gwa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gwa_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_method (method_reg),
        .in_data    (s_tdata),
        .in_last    (s_tlast),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .m_tuser    (user)
    );

    assign m_tuser = user[0];
    assign m_tlast = user[1];

    // Output register holds its result while the receiver stalls.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed under stall");

    // No input is taken while a result is pending.
    a_noin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input accepted during emission");

    // An empty group reports zero means.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[OUT_TDATA_W-1:GROUP_W] == '0)
        else $error("empty group with nonzero mean");

endmodule

// ===== verif/grouped_weighted_average_test.sv =====
`timescale 1ns / 1ps

// Scoreboard for the per-group averages. It keeps its own copy of the
// accumulated sums, weights and highest group, and queues expected results.
class group_mean_board;
    typedef struct packed {
        logic [5:0]  grp;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] mc;
        logic        empty;
        logic        lastg;
    } mean_rec_t;

    logic signed [63:0] sums[64][3];
    logic [63:0]        weights[64];
    int                 top_group;
    bit                 area_mode;
    mean_rec_t          pending[$];
    int                 mismatches;

    function void clear_store();
        foreach (weights[g]) begin
            weights[g] = '0;
            for (int j = 0; j < 3; j++) sums[g][j] = '0;
        end
        top_group = 0;
    endfunction

    function logic [31:0] quotient(logic signed [63:0] s, logic [63:0] w);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] q;
        neg = s[63];
        mag = neg ? (64'd0 - s) : s;
        q = mag / w;
        if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
        return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    // Accumulate one accepted triangle; on the last one queue the emission run.
    function void note_triangle(logic [5:0] g, logic [31:0] v[3], logic [31:0] area,
                                logic lastm);
        logic signed [63:0] add;
        logic signed [64:0] wide;
        logic [64:0]        wsum;
        mean_rec_t          r;
        for (int j = 0; j < 3; j++) begin
            add = area_mode ? $signed(v[j]) * $signed({32'd0, area})
                            : 64'($signed(v[j]));
            wide = 65'(sums[g][j]) + 65'(add);
            if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) sums[g][j] = 64'sh7FFF_FFFF_FFFF_FFFF;
            else if (wide < -65'sh0_8000_0000_0000_0000)
                sums[g][j] = 64'sh8000_0000_0000_0000;
            else sums[g][j] = wide[63:0];
        end
        wsum = {1'b0, weights[g]} + (area_mode ? 65'(area) : 65'd1);
        weights[g] = wsum[64] ? '1 : wsum[63:0];
        if (g > top_group) top_group = g;
        if (!lastm) return;
        for (int k = 0; k <= top_group; k++) begin
            r.grp = 6'(k);
            r.empty = weights[k] == 0;
            r.lastg = k == top_group;
            r.ma = r.empty ? '0 : quotient(sums[k][0], weights[k]);
            r.mb = r.empty ? '0 : quotient(sums[k][1], weights[k]);
            r.mc = r.empty ? '0 : quotient(sums[k][2], weights[k]);
            pending.insert(pending.size(), r);
        end
        clear_store();
    endfunction

    function void check_mean(mean_rec_t got);
        mean_rec_t want;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result for group %0d", got.grp);
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected grp %0d a %h b %h c %h e %b l %b, got grp %0d a %h b %h c %h e %b l %b",
                         want.grp, want.ma, want.mb, want.mc, want.empty, want.lastg,
                         got.grp, got.ma, got.mb, got.mc, got.empty, got.lastg);
        end
    endfunction
endclass

module grouped_weighted_average_test;
    import gwa_pkg::*;

    logic                   aclk = 0;
    logic                   aresetn = 0;
    logic                   s_tvalid = 0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 0;
    logic                   m_tvalid;
    logic                   m_tready = 0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 0;
    logic                   cfg_ready;
    logic                   cfg_data = 0;

    group_mean_board board;
    int              cycles;
    bit              recv_busy;

    grouped_weighted_average u_top (.*);

    always #5 aclk = ~aclk;

    // Cycle limit: sized with room to spare for the case in which every triangle
    // closed a set of 64 groups under receiver stalls; past it the run fails.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 5000000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // The receiver alternates calm stretches with heavy back pressure or with
    // no stall at all, switching on bits 8 and 9 of the cycle counter.
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 0;
        else if (cycles[8]) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= cycles[9] ? 1'b1 : ($urandom_range(0, 3) == 0);
    end

    // Every result transaction is compared at the edge where it is accepted.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_mean({m_tdata[5:0], m_tdata[37:6], m_tdata[69:38],
                              m_tdata[101:70], m_tuser, m_tlast});
    end

    // Send one triangle and hold it until the block accepts the transaction.
    // Valid stays high afterward; the caller drops it before any idle time.
    task automatic send_triangle(logic [5:0] g, logic [31:0] a, logic [31:0] b,
                                 logic [31:0] c, logic [31:0] area, logic lastm);
        logic [31:0] v[3];
        v = '{a, b, c};
        s_tvalid <= 1;
        s_tdata <= {2'b0, area, c, b, a, g};
        s_tlast <= lastm;
        do @(posedge aclk); while (!s_tready);
        board.note_triangle(g, v, area, lastm);
    endtask

    // Random gap between bursts; sometimes none at all.
    task automatic sender_gap();
        int n;
        n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
        if (n > 0) s_tvalid <= 0;
        repeat (n) @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // Configuration is written only with the block idle and nothing pending.
    task automatic write_method(bit m);
        drain();
        cfg_valid <= 1;
        cfg_data <= m;
        do @(posedge aclk); while (!cfg_ready);
        board.area_mode = m;
        cfg_valid <= 0;
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 200) - 100;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int burst;
        board = new();
        board.clear_store();
        board.area_mode = 1;
        cycles = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part: area mode with extreme values and the widest area.
        send_triangle(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_triangle(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 0);
        send_triangle(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 32'hFFFF_FFFF, 0);
        send_triangle(2, 32'd7, -32'sd7, 32'd0, 32'h0001_8000, 0);
        // A zero area leaves group 5 empty while group 63 sets the top id.
        send_triangle(5, 32'd9, 32'd9, 32'd9, 32'd0, 0);
        send_triangle(63, -32'sd3, 32'd3, 32'd1, 32'h0000_0001, 1);
        // A run whose only triangle carries no weight still emits group 0.
        send_triangle(0, 32'd1, 32'd1, 32'd1, 32'd0, 1);

        // Count mode, including extreme values and a lone last mark.
        write_method(0);
        send_triangle(1, 32'h8000_0000, 32'h7FFF_FFFF, -32'sd7, 32'hFFFF_FFFF, 0);
        send_triangle(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'd2, 32'd0, 0);
        send_triangle(3, 32'd10, -32'sd10, 32'd11, 32'h1234_5678, 1);
        send_triangle(0, 32'd4, 32'd5, 32'd6, 32'd0, 1);

        // Switching the method inside one set mixes count and area terms in one group.
        send_triangle(4, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3, 32'd1, 0);
        write_method(1);
        send_triangle(4, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3, 32'h0000_0001, 0);
        write_method(0);
        send_triangle(4, 32'd1, 32'd1, 32'd1, 32'd0, 1);

        // Random sets, mostly small group ranges, with an occasional wide one.
        for (int i = 0; i < 160; ) begin
            if (i % 40 == 0) write_method($urandom_range(0, 1));
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && i < 160; k++, i++)
                send_triangle(($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                         : $urandom_range(0, 7),
                              rand_value(), rand_value(), rand_value(),
                              $urandom, $urandom_range(0, 11) == 0);
            // Hold off once in a while until the scoreboard has caught up.
            if ($urandom_range(0, 9) == 0) drain();
            sender_gap();
        end
        send_triangle($urandom_range(0, 63), $urandom, $urandom, $urandom, $urandom, 1);
        drain();

        if (board.mismatches == 0 && board.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/gwa_pkg.sv
design/gwa_ctrl.sv
design/gwa_div.sv
design/gwa_dp.sv
design/grouped_weighted_average.sv
verif/grouped_weighted_average_test.sv
